// ===== rtl/bit_sliced_counter_accumulate_defines.svh =====
`ifndef BIT_SLICED_COUNTER_ACCUMULATE_DEFINES_SVH
`define BIT_SLICED_COUNTER_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define BSCA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsca check failed");

// Next-cycle implication, held off while reset is high.
`define BSCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsca check failed");

// Next-cycle implication that is checked through reset as well.
`define BSCA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bsca check failed");

`endif

// ===== rtl/bsca_pkg.sv =====
`default_nettype none

package bsca_pkg;

   localparam int WORDS       = 256;
   localparam int SLICE_COUNT = 8;
   localparam int DATA_W      = 64;
   localparam int ADDR_W      = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_SUB   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // One word's counters: slice j holds bit j of the 64 counters.
   typedef logic [SLICE_COUNT-1:0][DATA_W-1:0] row_type;

endpackage

`default_nettype wire

// ===== rtl/bsca_channels.sv =====
`default_nettype none

interface bsca_req_if;
   logic                        valid;
   logic                        ready;
   bsca_pkg::op_type            op;
   logic [7:0]                  word_index;
   logic [bsca_pkg::DATA_W-1:0] data_word;
   logic [3:0]                  active_slices;
   logic [7:0]                  threshold;
   logic [2:0]                  slice_select;

   modport source (
      output valid, op, word_index, data_word, active_slices, threshold, slice_select,
      input  ready
   );
   modport sink (
      input  valid, op, word_index, data_word, active_slices, threshold, slice_select,
      output ready
   );
endinterface

interface bsca_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsca_pkg::DATA_W-1:0] top_slice_word;
   logic [bsca_pkg::DATA_W-1:0] slice_word;
   logic [bsca_pkg::DATA_W-1:0] carry_out_word;

   modport source (
      output valid, top_slice_word, slice_word, carry_out_word,
      input  ready
   );
   modport sink (
      input  valid, top_slice_word, slice_word, carry_out_word,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/bit_sliced_counter_accumulate.sv =====
`default_nettype none

// Bit-sliced counter bank: one small counter per bit position, 64 positions per word,
// each word's counters held as SLICE_COUNT slice words in a single memory row. Every
// item (clear, add, subtract threshold, read) is a read-modify-write of one row and
// yields one result item. Throughput is one item per clock while the result side is not
// stalled, set by the single compute stage between the input register and the result
// register; an accepted item waits in that stage until the result register is free.
// The row memory has one registered read port, used at accept, and one write port,
// used when the item leaves the compute stage; the last written row is forwarded so
// back-to-back items on the same word see each other's update. A per-row valid bit,
// cleared by reset, makes unwritten rows read as zero, so there is no clearing pass
// after reset. Words at or above WORDS return all-zero results and change nothing.
module bit_sliced_counter_accumulate (
   input  wire logic   clock,
   input  wire logic   reset,
   bsca_req_if.sink    req,
   bsca_rsp_if.source  rsp
);

   localparam int SC = bsca_pkg::SLICE_COUNT;
   localparam int DW = bsca_pkg::DATA_W;
   localparam int AW = bsca_pkg::ADDR_W;

   // row store and its valid bits
   bsca_pkg::row_type   mem_ff [bsca_pkg::WORDS];
   logic [bsca_pkg::WORDS-1:0] row_valid_ff;

   // compute stage
   logic                s1_valid_ff, s1_valid_in;
   bsca_pkg::op_type    s1_op_ff;
   logic [7:0]          s1_word_ff;
   logic [DW-1:0]       s1_data_ff;
   logic [3:0]          s1_active_ff;
   logic [7:0]          s1_thr_ff;
   logic [2:0]          s1_sel_ff;
   bsca_pkg::row_type   rd_row_ff;
   logic                rd_valid_ff;

   // last written row
   logic                fwd_valid_ff;
   logic [AW-1:0]       fwd_addr_ff;
   bsca_pkg::row_type   fwd_row_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]       top_ff, slice_ff, carry_ff;

   logic                accept, out_free, s1_adv, s1_in_range, wr_en, fwd_hit;
   logic [AW-1:0]       req_addr, s1_addr;
   bsca_pkg::row_type   old_row, new_row;
   logic [DW-1:0]       bits, cry, borrow, nb, a, b;
   logic [7:0]          thr_sh;
   logic [DW-1:0]       top_in, slice_in, carry_in;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !reset && (!s1_valid_ff || out_free);
   assign accept    = req.valid && req.ready;

   assign req_addr    = AW'(req.word_index);
   assign s1_addr     = AW'(s1_word_ff);
   assign s1_in_range = {3'b000, s1_word_ff} < 11'(bsca_pkg::WORDS);
   assign wr_en       = s1_adv && s1_in_range;
   assign fwd_hit     = fwd_valid_ff && (fwd_addr_ff == s1_addr);

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      old_row  = fwd_hit ? fwd_row_ff : (rd_valid_ff ? rd_row_ff : '0);
      new_row  = old_row;
      bits     = s1_data_ff;
      cry      = '0;
      borrow   = '0;
      nb       = '0;
      a        = '0;
      b        = '0;
      thr_sh   = '0;
      unique case (s1_op_ff)
         bsca_pkg::OP_CLEAR: begin
            new_row = '0;
         end
         bsca_pkg::OP_ADD: begin
            // half-adder ripple through the active slices only
            for (int j = 0; j < SC; j++) begin
               if (j < int'(s1_active_ff)) begin
                  cry        = new_row[j] & bits;
                  new_row[j] = new_row[j] ^ bits;
                  bits       = cry;
               end
            end
         end
         bsca_pkg::OP_SUB: begin
            for (int j = 0; j < SC; j++) begin
               thr_sh     = 8'(s1_thr_ff >> j);
               a          = new_row[j];
               b          = {DW{thr_sh[0]}};
               nb         = (~a & b) | (~(a ^ b) & borrow);
               new_row[j] = a ^ b ^ borrow;
               borrow     = nb;
            end
         end
         bsca_pkg::OP_READ: begin
         end
         default: begin
         end
      endcase

      top_in   = new_row[SC-1];
      slice_in = '0;
      for (int j = 0; j < SC; j++) begin
         if (int'(s1_sel_ff) == j) begin
            slice_in = new_row[j];
         end
      end
      carry_in = (s1_op_ff == bsca_pkg::OP_ADD) ? bits : '0;
      if (!s1_in_range) begin
         top_in   = '0;
         slice_in = '0;
         carry_in = '0;
      end
   end

   // memory: registered read at accept, write as the item leaves the compute stage
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= mem_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[s1_addr] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            rd_valid_ff <= row_valid_ff[req_addr];
         end
         if (wr_en) begin
            row_valid_ff[s1_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req.op;
         s1_word_ff   <= req.word_index;
         s1_data_ff   <= req.data_word;
         s1_active_ff <= req.active_slices;
         s1_thr_ff    <= req.threshold;
         s1_sel_ff    <= req.slice_select;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_row_ff  <= new_row;
      end
      if (s1_adv) begin
         top_ff   <= top_in;
         slice_ff <= slice_in;
         carry_ff <= carry_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.top_slice_word = top_ff;
   assign rsp.slice_word     = slice_ff;
   assign rsp.carry_out_word = carry_ff;

endmodule

`default_nettype wire

// ===== rtl/bsca_checker.sv =====
`default_nettype none

`include "bit_sliced_counter_accumulate_defines.svh"

module bsca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_top_slice_word,
   input wire logic [63:0] rsp_slice_word,
   input wire logic [63:0] rsp_carry_out_word
);

   logic req_accept;

   assign req_accept = req_valid && req_ready;

   // a stalled result item holds
   `BSCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_top_slice_word) && $stable(rsp_slice_word) && $stable(rsp_carry_out_word))

   // input only backs up when the result register is full and stalled
   `BSCA_ASSERT_NOW(a_ready_only_on_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a fresh result comes from an item that went straight from the compute stage into the empty result register
   `BSCA_ASSERT_NOW(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_accept, 2))

   // reset empties the result register
   `BSCA_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind bit_sliced_counter_accumulate bsca_checker u_bsca_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_top_slice_word (rsp.top_slice_word),
   .rsp_slice_word     (rsp.slice_word),
   .rsp_carry_out_word (rsp.carry_out_word)
);

`default_nettype wire
